FILE: rtl/pob_pkg.sv
// shared types and constants for the pulsed output bank
`default_nettype none

package pob_pkg;

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned BANK_W = 8;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SET,
    OP_FUNC,
    OP_LOAD
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_A,
    CFG_PULSE_B,
    CFG_PULSE_C,
    CFG_PULSE_D,
    CFG_ENABLE,
    CFG_INVERT,
    CFG_FUNC_MAP,
    CFG_NONE
  } cfg_idx_e;

  // per-output tick inputs
  typedef struct packed {
    logic              mix_bit;
    logic              scan_bit;
    logic              pulsed_bit;
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  ptime;
  } lane_in_t;

  // per-output tick results
  typedef struct packed {
    logic              mix_bit;
    logic              pulsed_bit;
    logic              rewrite;
    logic [CNT_W-1:0]  cnt;
  } lane_out_t;

endpackage

`default_nettype wire

FILE: rtl/pulsed_output_bank_top.sv
// top level of the pulsed output bank: item pipeline, state and counter memory
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | in        | in_valid_i/in_ready_o | opcode, output_index, level, func_bit,
//          |           |                       | forced_mask
//  out     | out       | out_valid_o/out_ready_i | pin/output levels, pulsed, func, flags
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// the counter row of an item is read from memory as it is taken, then the item
// executes and its result lands in the output register; one item per cycle
// sustained while the output is not stalled; the counter row read of a following
// tick takes the write-back of the executing tick by forwarding
// reset clears the configuration and bank state; the counter row reads as zero until a tick writes it
// a stalled output holds the executing item, and the input backs up behind it
`default_nettype none

module pulsed_output_bank_top
  import pob_pkg::*;
#(
  parameter int unsigned NUM_OUTPUTS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [63:0]           cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic [2:0]            output_index_i,
  input  logic                  level_i,
  input  logic [2:0]            func_bit_i,
  input  logic [7:0]            forced_mask_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            pin_levels_o,
  output logic [7:0]            output_levels_o,
  output logic [7:0]            pulsed_mask_o,
  output logic [7:0]            func_state_o,
  output logic [7:0]            func_present_o,
  output logic                  changed_o,
  output logic                  status_o
);

  localparam int unsigned ROW_W = NUM_OUTPUTS * CNT_W;
  localparam logic [BANK_W-1:0] BANK = BANK_W'((9'd1 << NUM_OUTPUTS) - 9'd1);

  // configuration
  logic [31:0]        ptime_q [4];
  logic [BANK_W-1:0]  enable_q;
  logic [BANK_W-1:0]  invert_q;
  logic [63:0]        fmap_q;

  // bank state
  logic [BANK_W-1:0]  ls_q, ls_d;
  logic [BANK_W-1:0]  forced_q, forced_d;
  logic [BANK_W-1:0]  pulsed_q, pulsed_d;
  logic [BANK_W-1:0]  driven_q, driven_d;
  logic [BANK_W-1:0]  scanned_q, scanned_d;
  logic [BANK_W-1:0]  rep_lvl_q, rep_lvl_d;
  logic [BANK_W-1:0]  rep_pul_q, rep_pul_d;
  logic [BANK_W-1:0]  grp_q, grp_d;

  // counter memory, one row holding every output's countdown
  logic [ROW_W-1:0]   cnt_mem [1];
  logic               row_vld_q;
  logic [ROW_W-1:0]   cnt_rd_q;
  logic [ROW_W-1:0]   cnt_wr;
  logic               cnt_we;

  // execute stage
  logic               a_valid_q;
  op_e                a_op_q;
  logic [2:0]         a_idx_q;
  logic               a_lvl_q;
  logic [2:0]         a_fb_q;
  logic [7:0]         a_mask_q;
  logic               adv;
  logic               accept;

  // output register
  logic               o_valid_q;
  logic [7:0]         o_pin_q, o_lvl_q, o_pul_q, o_grp_q, o_pres_q;
  logic               o_chg_q, o_stat_q;

  logic [BANK_W-1:0]  en;
  logic [BANK_W-1:0]  mix0;
  logic [BANK_W-1:0]  t_pulsed, t_mix, t_rew, sel, present;
  logic               changed, status;

  lane_in_t           lane_in  [NUM_OUTPUTS];
  lane_out_t          lane_out [NUM_OUTPUTS];

  assign cfg_ready_o = 1'b1;
  assign adv         = a_valid_q && (!o_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = !a_valid_q || adv;
  assign cnt_we      = adv && (a_op_q == OP_TICK);

  assign en   = enable_q & BANK;
  assign mix0 = (ls_q | forced_q) & en;

  for (genvar g = 0; g < NUM_OUTPUTS; g++) begin : g_lane
    assign lane_in[g].mix_bit    = mix0[g];
    assign lane_in[g].scan_bit   = scanned_q[g];
    assign lane_in[g].pulsed_bit = pulsed_q[g];
    assign lane_in[g].cnt        = cnt_rd_q[g*CNT_W +: CNT_W];
    assign lane_in[g].ptime      = ptime_q[g/2][(g%2)*CNT_W +: CNT_W];
    assign cnt_wr[g*CNT_W +: CNT_W] = lane_out[g].cnt;

    pob_lane u_lane (
      .lane_i (lane_in[g]),
      .lane_o (lane_out[g])
    );
  end

  always_comb begin
    t_pulsed = '0;
    t_mix    = '0;
    t_rew    = '0;
    sel      = '0;
    present  = '0;
    for (int p = 0; p < NUM_OUTPUTS; p++) begin
      t_pulsed[p] = lane_out[p].pulsed_bit;
      t_mix[p]    = lane_out[p].mix_bit;
      t_rew[p]    = lane_out[p].rewrite;
      sel[p]      = fmap_q[{3'(p), a_fb_q}];
      present     = present | fmap_q[8*p +: 8];
    end
  end

  // item execution against the bank state
  always_comb begin
    ls_d      = ls_q;
    forced_d  = forced_q;
    pulsed_d  = pulsed_q;
    driven_d  = driven_q;
    scanned_d = scanned_q;
    rep_lvl_d = rep_lvl_q;
    rep_pul_d = rep_pul_q;
    grp_d     = grp_q;
    changed   = 1'b0;
    status    = 1'b0;
    unique case (a_op_q)
      OP_TICK: begin
        pulsed_d  = t_pulsed;
        driven_d  = (driven_q & ~(t_rew & en))
                  | (((ls_q | forced_q) ^ t_pulsed) & t_rew & en);
        scanned_d = t_mix;
        changed   = (t_mix != rep_lvl_q) || (t_pulsed != rep_pul_q);
        rep_lvl_d = t_mix;
        rep_pul_d = t_pulsed;
      end
      OP_SET: begin
        // en is zero above the bank, so this also rejects nonexistent outputs
        if (en[a_idx_q]) begin
          ls_d[a_idx_q]     = a_lvl_q;
          driven_d[a_idx_q] = (a_lvl_q | forced_q[a_idx_q]) ^ pulsed_q[a_idx_q];
        end else begin
          status = 1'b1;
        end
      end
      OP_FUNC: begin
        grp_d[a_fb_q] = a_lvl_q;
        ls_d     = a_lvl_q ? (ls_q | sel) : (ls_q & ~sel);
        driven_d = (driven_q & ~(sel & en)) | (((ls_d | forced_q) ^ pulsed_q) & sel & en);
      end
      OP_LOAD: begin
        forced_d = a_mask_q;
      end
      default: begin
        status = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) begin
        ptime_q[r] <= '0;
      end
      enable_q <= '0;
      invert_q <= '0;
      fmap_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PULSE_A:  ptime_q[0] <= cfg_data_i[31:0];
        CFG_PULSE_B:  ptime_q[1] <= cfg_data_i[31:0];
        CFG_PULSE_C:  ptime_q[2] <= cfg_data_i[31:0];
        CFG_PULSE_D:  ptime_q[3] <= cfg_data_i[31:0];
        CFG_ENABLE:   enable_q   <= cfg_data_i[7:0];
        CFG_INVERT:   invert_q   <= cfg_data_i[7:0];
        CFG_FUNC_MAP: fmap_q     <= cfg_data_i;
        default:      enable_q   <= enable_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q      <= '0;
      forced_q  <= '0;
      pulsed_q  <= '0;
      driven_q  <= '0;
      scanned_q <= '0;
      rep_lvl_q <= '0;
      rep_pul_q <= '0;
      grp_q     <= '0;
    end else if (adv) begin
      ls_q      <= ls_d;
      forced_q  <= forced_d;
      pulsed_q  <= pulsed_d;
      driven_q  <= driven_d;
      scanned_q <= scanned_d;
      rep_lvl_q <= rep_lvl_d;
      rep_pul_q <= rep_pul_d;
      grp_q     <= grp_d;
    end
  end

  // counter memory write port
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[0] <= cnt_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= 1'b0;
    end else if (cnt_we) begin
      row_vld_q <= 1'b1;
    end
  end

  // registered read as an item is taken, forwarding the write-back in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (cnt_we) begin
        cnt_rd_q <= cnt_wr;
      end else if (row_vld_q) begin
        cnt_rd_q <= cnt_mem[0];
      end else begin
        cnt_rd_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_op_q   <= op_e'(opcode_i);
      a_idx_q  <= output_index_i;
      a_lvl_q  <= level_i;
      a_fb_q   <= func_bit_i;
      a_mask_q <= forced_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (adv) begin
      o_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_pin_q  <= (driven_d ^ invert_q) & en;
      o_lvl_q  <= ((ls_d | forced_d) ^ pulsed_d) & BANK;
      o_pul_q  <= pulsed_d;
      o_grp_q  <= grp_d;
      o_pres_q <= present;
      o_chg_q  <= changed;
      o_stat_q <= status;
    end
  end

  assign out_valid_o     = o_valid_q;
  assign pin_levels_o    = o_pin_q;
  assign output_levels_o = o_lvl_q;
  assign pulsed_mask_o   = o_pul_q;
  assign func_state_o    = o_grp_q;
  assign func_present_o  = o_pres_q;
  assign changed_o       = o_chg_q;
  assign status_o        = o_stat_q;

  // the scanned copy and the reported levels are both loaded by every tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scanned_q == rep_lvl_q)
    else $error("scanned copy and reported levels disagree");

  // pulse flags move only when a tick executes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cnt_we |=> $stable(pulsed_q))
    else $error("pulse flags changed outside a tick");

  // a disabled output keeps its driven level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((driven_q ^ $past(driven_q)) & ~$past(enable_q)) == '0)
    else $error("driven level of a disabled output changed");

  // once a tick has written the counter row it stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_we |=> row_vld_q)
    else $error("counter row not valid after write-back");

  // a held result never loses its slot to a new one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && !out_ready_i) |-> !adv)
    else $error("execute stage overwrote a stalled result");

endmodule

`default_nettype wire

FILE: rtl/pob_lane.sv
// tick update of one output: timeout countdown, pulse flag and restart
`default_nettype none

module pob_lane
  import pob_pkg::*;
(
  input  lane_in_t  lane_i,
  output lane_out_t lane_o
);

  logic             neg;
  logic             pos;
  logic             clr;
  logic             pulsed1;
  logic [CNT_W-1:0] cnt1;
  logic             mix;
  logic             rew;
  logic [CNT_W-1:0] mag;

  assign neg = lane_i.ptime[CNT_W-1];
  assign pos = !neg && (lane_i.ptime != '0);
  // timeout is cancelled once the level sits in the other state
  assign clr = lane_i.mix_bit ? neg : pos;
  // most negative time gives a countdown of 32768, which still fits
  assign mag = neg ? CNT_W'(-lane_i.ptime) : lane_i.ptime;

  always_comb begin
    if (clr) begin
      cnt1    = '0;
      pulsed1 = 1'b0;
    end else if (lane_i.cnt != '0) begin
      cnt1    = lane_i.cnt - CNT_W'(1);
      pulsed1 = lane_i.pulsed_bit | (lane_i.cnt == CNT_W'(1));
    end else begin
      cnt1    = lane_i.cnt;
      pulsed1 = lane_i.pulsed_bit;
    end
  end

  assign mix = lane_i.mix_bit ^ pulsed1;
  assign rew = mix ^ lane_i.scan_bit;

  always_comb begin
    lane_o.mix_bit    = mix;
    lane_o.pulsed_bit = pulsed1;
    lane_o.rewrite    = rew;
    if (rew && (mix ? pos : neg)) begin
      lane_o.cnt = mag;
    end else begin
      lane_o.cnt = cnt1;
    end
  end

endmodule

`default_nettype wire

FILE: test/pulsed_output_bank_checker.sv
// result checker for the pulsed output bank: tracks the bank state and compares each result
`timescale 1ns / 100ps

module pulsed_output_bank_checker
  import pob_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i,

  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [1:0]           opcode_i,
  input  logic [2:0]           output_index_i,
  input  logic                 level_i,
  input  logic [2:0]           func_bit_i,
  input  logic [7:0]           forced_mask_i,

  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [7:0]           pin_levels_i,
  input  logic [7:0]           output_levels_i,
  input  logic [7:0]           pulsed_mask_i,
  input  logic [7:0]           func_state_i,
  input  logic [7:0]           func_present_i,
  input  logic                 changed_i,
  input  logic                 status_i,

  output int unsigned          errors_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [7:0] pins;
    logic [7:0] levels;
    logic [7:0] pulsed;
    logic [7:0] groups;
    logic [7:0] present;
    logic       changed;
    logic       status;
  } bank_view_t;

  // register copy
  logic [31:0] pulse_reg [4];
  logic [7:0]  enable_q;
  logic [7:0]  invert_q;
  logic [63:0] func_map_q;

  // bank state copy
  logic [7:0]  logical_q;
  logic [7:0]  forced_q;
  logic [7:0]  pulsed_q;
  logic [7:0]  driven_q;
  logic [7:0]  scanned_q;
  logic [7:0]  told_levels_q;
  logic [7:0]  told_pulsed_q;
  logic [15:0] hold_cnt [8];
  logic [7:0]  group_q;

  bank_view_t  levels_due [$];

  initial errors_o = 0;

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors_o++;
  endtask

  function automatic void clear_bank();
    for (int i = 0; i < 4; i++) pulse_reg[i] = '0;
    for (int i = 0; i < 8; i++) hold_cnt[i] = '0;
    enable_q      = '0;
    invert_q      = '0;
    func_map_q    = '0;
    logical_q     = '0;
    forced_q      = '0;
    pulsed_q      = '0;
    driven_q      = '0;
    scanned_q     = '0;
    told_levels_q = '0;
    told_pulsed_q = '0;
    group_q       = '0;
  endfunction

  initial clear_bank();

  // signed pulse time of one output, widened so that -32768 has a magnitude
  function automatic logic signed [16:0] pulse_time(int unsigned p);
    logic [15:0] h;
    h = pulse_reg[p >> 1][(p & 1) * 16 +: 16];
    return $signed({h[15], h});
  endfunction

  function automatic logic [7:0] combined_levels();
    return (logical_q | forced_q) ^ pulsed_q;
  endfunction

  function automatic void drive_pin(int unsigned p);
    logic [7:0] c;
    c = combined_levels();
    if (enable_q[p]) driven_q[p] = c[p];
  endfunction

  function automatic void set_output(int unsigned p, logic v);
    logical_q[p] = v;
    drive_pin(p);
  endfunction

  function automatic logic run_tick();
    logic [7:0]         mix;
    logic signed [16:0] t;
    logic signed [16:0] mag;
    logic               ch;
    mix = (logical_q | forced_q) & enable_q;
    for (int i = 0; i < 8; i++) begin
      t = pulse_time(i);
      if (mix[i] ? (t < 0) : (t > 0)) begin
        hold_cnt[i] = '0;
        pulsed_q[i] = 1'b0;
      end else if (hold_cnt[i] != 0) begin
        hold_cnt[i] = hold_cnt[i] - 16'd1;
        if (hold_cnt[i] == 0) pulsed_q[i] = 1'b1;
      end
    end
    mix = mix ^ pulsed_q;
    for (int i = 0; i < 8; i++) begin
      if (mix[i] != scanned_q[i]) begin
        t = pulse_time(i);
        if (mix[i] ? (t > 0) : (t < 0)) begin
          mag = (t > 0) ? t : -t;
          hold_cnt[i] = mag[15:0];
        end
        drive_pin(i);
      end
    end
    scanned_q = mix;
    ch = (mix != told_levels_q) || (pulsed_q != told_pulsed_q);
    told_levels_q = mix;
    told_pulsed_q = pulsed_q;
    return ch;
  endfunction

  function automatic bank_view_t advance_bank(logic [1:0] op, logic [2:0] idx, logic lvl,
                                              logic [2:0] fb, logic [7:0] fm);
    bank_view_t v;
    v = '0;
    case (op_e'(op))
      OP_TICK: v.changed = run_tick();
      OP_SET: begin
        if (enable_q[idx]) set_output(idx, lvl);
        else v.status = 1'b1;
      end
      OP_FUNC: begin
        group_q[fb] = lvl;
        for (int p = 0; p < 8; p++)
          if (func_map_q[8 * p + fb]) set_output(p, lvl);
      end
      default: forced_q = fm;
    endcase
    for (int p = 0; p < 8; p++) v.present |= func_map_q[8 * p +: 8];
    v.pins   = (driven_q ^ invert_q) & enable_q;
    v.levels = combined_levels();
    v.pulsed = pulsed_q;
    v.groups = group_q;
    return v;
  endfunction

  function automatic void load_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    case (cfg_idx_e'(idx))
      CFG_PULSE_A, CFG_PULSE_B, CFG_PULSE_C, CFG_PULSE_D: pulse_reg[idx[1:0]] = data[31:0];
      CFG_ENABLE:   enable_q   = data[7:0];
      CFG_INVERT:   invert_q   = data[7:0];
      CFG_FUNC_MAP: func_map_q = data;
      default: ;
    endcase
  endfunction

  task automatic compare_result(bank_view_t want);
    if (pin_levels_i !== want.pins)
      report_mismatch($sformatf("pin_levels %h, want %h", pin_levels_i, want.pins));
    if (output_levels_i !== want.levels)
      report_mismatch($sformatf("output_levels %h, want %h", output_levels_i, want.levels));
    if (pulsed_mask_i !== want.pulsed)
      report_mismatch($sformatf("pulsed_mask %h, want %h", pulsed_mask_i, want.pulsed));
    if (func_state_i !== want.groups)
      report_mismatch($sformatf("func_state %h, want %h", func_state_i, want.groups));
    if (func_present_i !== want.present)
      report_mismatch($sformatf("func_present %h, want %h", func_present_i, want.present));
    if (changed_i !== want.changed)
      report_mismatch($sformatf("changed %b, want %b", changed_i, want.changed));
    if (status_i !== want.status)
      report_mismatch($sformatf("status %b, want %b", status_i, want.status));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_bank();
      levels_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (levels_due.size() == 0) report_mismatch("result with no item waiting");
        else compare_result(levels_due.pop_front());
      end
      if (cfg_valid_i && cfg_ready_i) load_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i)
        levels_due.push_back(advance_bank(opcode_i, output_index_i, level_i, func_bit_i,
                                          forced_mask_i));
    end
    pending_o = levels_due.size();
  end

endmodule

FILE: test/tb_pulsed_output_bank_top.sv
// testbench top for the pulsed output bank: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_pulsed_output_bank_top;
  import pob_pkg::*;

  localparam int unsigned LONG_HOLD  = 80;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_LEN  = 54;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [63:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           opcode_i;
  logic [2:0]           output_index_i;
  logic                 level_i;
  logic [2:0]           func_bit_i;
  logic [7:0]           forced_mask_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [7:0]           pin_levels_o;
  logic [7:0]           output_levels_o;
  logic [7:0]           pulsed_mask_o;
  logic [7:0]           func_state_o;
  logic [7:0]           func_present_o;
  logic                 changed_o;
  logic                 status_o;

  int unsigned          errors;
  int unsigned          pending;

  logic                 item_taken;
  logic                 result_taken;
  logic                 reg_taken;
  logic                 quiet;
  logic                 hold_req;
  logic                 hold_done;

  pulsed_output_bank_top DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .opcode_i, .output_index_i, .level_i, .func_bit_i,
    .forced_mask_i,
    .out_valid_o, .out_ready_i, .pin_levels_o, .output_levels_o, .pulsed_mask_o,
    .func_state_o, .func_present_o, .changed_o, .status_o
  );

  pulsed_output_bank_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .opcode_i, .output_index_i, .level_i,
    .func_bit_i, .forced_mask_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pin_levels_i(pin_levels_o),
    .output_levels_i(output_levels_o), .pulsed_mask_i(pulsed_mask_o),
    .func_state_i(func_state_o), .func_present_i(func_present_o),
    .changed_i(changed_o), .status_i(status_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // handshake flags sampled at the edge, read back at the following falling edge
  always @(posedge clk_i) begin
    item_taken   <= in_valid_i && in_ready_o;
    result_taken <= out_valid_o && out_ready_i;
    reg_taken    <= cfg_valid_i && cfg_ready_o;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!reg_taken);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_item(op_e op, logic [2:0] idx, logic lvl, logic [2:0] fb,
                           logic [7:0] fm);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    output_index_i <= idx;
    level_i        <= lvl;
    func_bit_i     <= fb;
    forced_mask_i  <= fm;
    do @(negedge clk_i); while (!item_taken);
  endtask

  // stop offering items and let every outstanding result come out
  task automatic drain_bank();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_time();
    int unsigned r;
    int          s;
    logic [15:0] edges [5];
    edges = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000};
    r = $urandom_range(0, 9);
    s = $urandom_range(0, 8);
    if (r < 7) return 16'(s - 4);
    if (r < 9) return edges[$urandom_range(0, 4)];
    return 16'($urandom);
  endfunction

  task automatic random_item();
    int unsigned r;
    op_e         op;
    r = $urandom_range(0, 99);
    if (r < 50)      op = OP_TICK;
    else if (r < 75) op = OP_SET;
    else if (r < 88) op = OP_FUNC;
    else             op = OP_LOAD;
    send_item(op, 3'($urandom), 1'($urandom), 3'($urandom), 8'($urandom));
  endtask

  // random side of the result channel, with one long hold-off on request
  initial begin : result_sink
    int unsigned wait_cycles;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      wait_cycles = quiet ? 0 : $urandom_range(0, 5);
      if (hold_req && !hold_done) begin
        wait_cycles = LONG_HOLD;
        hold_done   = 1'b1;
      end
      if (wait_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!result_taken);
    end
  end

  initial begin : stimulus
    logic [63:0] fmap;
    logic [7:0]  en;
    logic [7:0]  inv;
    logic [31:0] times [4];

    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_NONE;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_TICK;
    output_index_i = '0;
    level_i        = 1'b0;
    func_bit_i     = '0;
    forced_mask_i  = '0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // registers still at reset: nothing enabled
    send_item(OP_TICK, 3'd0, 1'b0, 3'd0, 8'h00);
    send_item(OP_SET, 3'd3, 1'b1, 3'd0, 8'h00);
    drain_bank();

    // out0 -2, out1 3, out2 max, out3 most negative, out4 1, out5 none, out6 -1, out7 2
    write_reg(CFG_PULSE_A, {16'd3, 16'hFFFE});
    write_reg(CFG_PULSE_B, {16'h8000, 16'h7FFF});
    write_reg(CFG_PULSE_C, {16'd0, 16'd1});
    write_reg(CFG_PULSE_D, {16'd2, 16'hFFFF});
    write_reg(CFG_ENABLE, 8'hEF);
    write_reg(CFG_INVERT, 8'h5A);
    write_reg(CFG_FUNC_MAP, 64'h8000_0002_0000_0301);

    send_item(OP_SET, 3'd0, 1'b1, 3'd0, 8'h00);
    send_item(OP_SET, 3'd4, 1'b1, 3'd0, 8'h00);   // disabled output
    send_item(OP_SET, 3'd1, 1'b1, 3'd0, 8'h00);
    repeat (4) send_item(OP_TICK, 3'd0, 1'b0, 3'd0, 8'h00);
    send_item(OP_FUNC, 3'd0, 1'b1, 3'd1, 8'h00);  // group reaches a disabled output
    send_item(OP_LOAD, 3'd0, 1'b0, 3'd0, 8'hFF);
    repeat (2) send_item(OP_TICK, 3'd0, 1'b0, 3'd0, 8'h00);
    send_item(OP_LOAD, 3'd0, 1'b0, 3'd0, 8'h00);
    repeat (3) send_item(OP_TICK, 3'd0, 1'b0, 3'd0, 8'h00);
    send_item(OP_FUNC, 3'd0, 1'b0, 3'd7, 8'h00);
    send_item(OP_SET, 3'd7, 1'b1, 3'd0, 8'h00);
    repeat (3) send_item(OP_TICK, 3'd0, 1'b0, 3'd0, 8'h00);
    send_item(OP_SET, 3'd6, 1'b0, 3'd0, 8'h00);
    send_item(OP_TICK, 3'd0, 1'b0, 3'd0, 8'h00);
    send_item(OP_FUNC, 3'd0, 1'b0, 3'd0, 8'h00);
    drain_bank();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0) begin
        times = '{32'h8000_7FFF, 32'h7FFF_8000, 32'h0001_FFFF, 32'hFFFF_0001};
        en    = 8'hFF;
        inv   = 8'hFF;
        fmap  = '1;
      end else if (ph == NUM_PHASES - 1) begin
        times = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        en    = 8'h00;
        inv   = 8'h00;
        fmap  = '0;
      end else begin
        for (int k = 0; k < 4; k++) times[k] = {pick_time(), pick_time()};
        en   = 8'($urandom) | 8'($urandom);
        inv  = 8'($urandom);
        fmap = {$urandom, $urandom} & {$urandom, $urandom};
      end
      write_reg(CFG_PULSE_A, times[0]);
      write_reg(CFG_PULSE_B, times[1]);
      write_reg(CFG_PULSE_C, times[2]);
      write_reg(CFG_PULSE_D, times[3]);
      write_reg(CFG_ENABLE, en);
      write_reg(CFG_INVERT, inv);
      write_reg(CFG_FUNC_MAP, fmap);

      quiet = (ph % 3 == 1);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // back-to-back items against a long receiver stall fill the pipeline
        if (ph == 1 && n == 8) hold_req = 1'b1;
        random_item();
      end
      drain_bank();
      quiet = 1'b0;
    end

    repeat (10) @(negedge clk_i);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
